// File: hw/rtl/gss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types, codes and constants of the timed gearshift sequencer.
// ----------------------------------------------------------------------------
package gss_pkg;

   localparam int TIME_BITS_DEF  = 16;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [2:0] {
      OP_TICK         = 3'd0,
      OP_UP           = 3'd1,
      OP_DOWN         = 3'd2,
      OP_NEUTRAL_UP   = 3'd3,
      OP_NEUTRAL_DOWN = 3'd4,
      OP_LIMITER_ON   = 3'd5,
      OP_LIMITER_OFF  = 3'd6,
      OP_GEAR_REPORT  = 3'd7
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_START_TIMES     = 3'd0,
      CSR_PUSH_UP_TIMES   = 3'd1,
      CSR_DOWN_TIMES      = 3'd2,
      CSR_NEUTRAL_TIMES_A = 3'd3,
      CSR_NEUTRAL_TIMES_B = 3'd4
   } csr_index_type;

   localparam logic [3:0] UP_STEP_START    = 4'd0;
   localparam logic [3:0] UP_STEP_PUSH     = 4'd1;
   localparam logic [3:0] UP_STEP_REBOUND  = 4'd2;
   localparam logic [3:0] UP_STEP_BRAKE    = 4'd3;
   localparam logic [3:0] UP_STEP_END      = 4'd4;
   localparam logic [3:0] DN_STEP_START    = 4'd5;
   localparam logic [3:0] DN_STEP_PUSH     = 4'd6;
   localparam logic [3:0] DN_STEP_REBOUND  = 4'd7;
   localparam logic [3:0] DN_STEP_BRAKE    = 4'd8;
   localparam logic [3:0] DN_STEP_END      = 4'd9;

   localparam logic [2:0] LEVER_NONE      = 3'd0;
   localparam logic [2:0] LEVER_PUSH_UP   = 3'd1;
   localparam logic [2:0] LEVER_PUSH_DOWN = 3'd2;
   localparam logic [2:0] LEVER_REBOUND   = 3'd3;
   localparam logic [2:0] LEVER_BRAKE     = 3'd4;
   localparam logic [2:0] LEVER_FREE      = 3'd5;

   localparam logic [1:0] CUT_NONE  = 2'd0;
   localparam logic [1:0] CUT_ON    = 2'd1;
   localparam logic [1:0] CUT_OFF   = 2'd2;
   localparam logic [1:0] BLIP_NONE = 2'd0;
   localparam logic [1:0] BLIP_ON   = 2'd1;
   localparam logic [1:0] BLIP_OFF  = 2'd2;
   localparam logic [1:0] LIM_NONE  = 2'd0;
   localparam logic [1:0] LIM_ON    = 2'd1;
   localparam logic [1:0] LIM_OFF   = 2'd2;

   localparam logic [6:0] CLUTCH_UP_POS  = 7'd80;
   localparam logic [6:0] CLUTCH_DN_POS  = 7'd60;
   localparam logic [6:0] CLUTCH_REL_POS = 7'd81;
   localparam logic [2:0] GEAR_NEUTRAL   = 3'd0;
   localparam logic [2:0] GEAR_MAX       = 3'd5;

   typedef struct packed {
      logic [2:0] operation;
      logic [2:0] gear_value;
      logic [6:0] clutch_position;
   } req_item_type;

   typedef struct packed {
      logic       clutch_set_valid;
      logic [6:0] clutch_set_value;
      logic       clutch_free;
      logic [1:0] ignition_cut;
      logic [1:0] throttle_blip;
      logic       buzzer_beep;
      logic [2:0] lever_action;
      logic [1:0] limiter_request;
      logic       shift_busy;
      logic [3:0] step_now;
   } rsp_item_type;

   typedef struct packed {
      logic [3:0] next_step;
      logic       shifting_up;
      logic       shifting_down;
      logic       setting_neutral;
      logic       leaving_neutral;
      logic [2:0] gear_now;
   } seq_state_type;

   typedef struct packed {
      logic [63:0] start_times;
      logic [63:0] push_up_times;
      logic [63:0] down_times;
      logic [63:0] neutral_times_a;
      logic [31:0] neutral_times_b;
   } timing_regs_type;

endpackage

// File: hw/rtl/gss_csr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_csr_regs
// Timing register file, written through the csr channel.
// ----------------------------------------------------------------------------
module gss_csr_regs import gss_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]               csr_wdata,
   output timing_regs_type           timing
);

   timing_regs_type timing_ff;
   timing_regs_type timing_in;

   assign csr_ready = 1'b1;
   assign timing    = timing_ff;

   always_comb begin
      timing_in = timing_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_START_TIMES:     timing_in.start_times     = csr_wdata;
            CSR_PUSH_UP_TIMES:   timing_in.push_up_times   = csr_wdata;
            CSR_DOWN_TIMES:      timing_in.down_times      = csr_wdata;
            CSR_NEUTRAL_TIMES_A: timing_in.neutral_times_a = csr_wdata;
            CSR_NEUTRAL_TIMES_B: timing_in.neutral_times_b = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff <= '0;
      end else begin
         timing_ff <= timing_in;
      end
   end

endmodule

// File: hw/rtl/gss_step_logic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_step_logic
// Per-request sequencing: command decode, countdown, step actions and timing.
// ----------------------------------------------------------------------------
module gss_step_logic import gss_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  req_item_type    item,
   input  seq_state_type   state_cur,
   input  logic [TIME_BITS:0] count_cur,
   input  timing_regs_type timing,
   output seq_state_type   state_nxt,
   output logic [TIME_BITS:0] count_nxt,
   output rsp_item_type    result
);

   localparam logic [TIME_BITS:0] COUNT_ONE = {{TIME_BITS{1'b0}}, 1'b1};

   function automatic logic [TIME_BITS-1:0] tfield(input logic [63:0] r,
                                                   input int unsigned k);
      logic [63:0] sh;
      begin
         sh = (k * TIME_BITS >= 64) ? 64'd0 : (r >> (k * TIME_BITS));
         return sh[TIME_BITS-1:0];
      end
   endfunction

   seq_state_type        st;
   logic [TIME_BITS:0]   cnt;
   rsp_item_type         res;
   logic                 run;
   logic                 load;
   logic                 n;
   logic [TIME_BITS-1:0] dur;
   logic [63:0]          ntb;
   op_type               op;

   assign ntb = {32'd0, timing.neutral_times_b};
   assign op  = op_type'(item.operation);

   always_comb begin
      st   = state_cur;
      cnt  = count_cur;
      res  = '0;
      run  = 1'b0;
      load = 1'b0;
      dur  = '0;
      n    = 1'b0;

      case (op)
         OP_TICK: begin
            if (cnt != '0) begin
               cnt = cnt - COUNT_ONE;
               run = (cnt == '0);
            end
         end
         OP_UP, OP_DOWN, OP_NEUTRAL_UP, OP_NEUTRAL_DOWN: begin
            if (op == OP_NEUTRAL_UP || op == OP_NEUTRAL_DOWN) begin
               st.setting_neutral = 1'b1;
            end else if (st.gear_now == GEAR_NEUTRAL) begin
               st.leaving_neutral = 1'b1;
            end
            if (!(state_cur.shifting_up || state_cur.shifting_down)) begin
               if (op == OP_UP || op == OP_NEUTRAL_UP) begin
                  st.shifting_up = 1'b1;
                  st.next_step   = UP_STEP_START;
               end else begin
                  st.shifting_down = 1'b1;
                  st.next_step     = DN_STEP_START;
               end
               run = 1'b1;
            end
         end
         OP_LIMITER_ON:  res.limiter_request = LIM_ON;
         OP_LIMITER_OFF: res.limiter_request = LIM_OFF;
         default: begin
            if (item.gear_value <= GEAR_MAX) begin
               st.gear_now = item.gear_value;
            end
         end
      endcase

      if (run) begin
         n = st.setting_neutral;
         case (st.next_step)
            UP_STEP_START: begin
               if (n) begin
                  res.clutch_set_valid = 1'b1;
                  res.clutch_set_value = CLUTCH_UP_POS;
               end else begin
                  res.ignition_cut = CUT_ON;
                  res.buzzer_beep  = 1'b1;
               end
               dur  = n ? tfield(timing.down_times, 3) : tfield(timing.start_times, 0);
               load = 1'b1;
            end
            UP_STEP_PUSH: begin
               if (!n) begin
                  res.ignition_cut = CUT_OFF;
               end
               res.lever_action = LEVER_PUSH_UP;
               if (n) begin
                  dur = tfield(timing.neutral_times_a, 0);
               end else begin
                  case (st.gear_now)
                     3'd1:    dur = tfield(timing.push_up_times, 0);
                     3'd3:    dur = tfield(timing.push_up_times, 2);
                     3'd4:    dur = tfield(timing.push_up_times, 3);
                     default: dur = tfield(timing.push_up_times, 1);
                  endcase
               end
               load = 1'b1;
            end
            UP_STEP_REBOUND: begin
               res.clutch_free  = n;
               res.lever_action = LEVER_REBOUND;
               dur  = n ? tfield(timing.neutral_times_a, 1) : tfield(timing.start_times, 1);
               load = 1'b1;
            end
            UP_STEP_BRAKE: begin
               res.lever_action = LEVER_BRAKE;
               dur  = n ? tfield(timing.neutral_times_a, 2) : tfield(timing.start_times, 2);
               load = 1'b1;
            end
            UP_STEP_END, DN_STEP_END: begin
               res.lever_action = LEVER_FREE;
               if (st.next_step == UP_STEP_END) begin
                  st.shifting_up = 1'b0;
               end else begin
                  st.shifting_down = 1'b0;
               end
               st.setting_neutral = 1'b0;
               st.leaving_neutral = 1'b0;
            end
            DN_STEP_START: begin
               if (n && item.clutch_position <= CLUTCH_UP_POS) begin
                  res.clutch_set_valid = 1'b1;
                  res.clutch_set_value = CLUTCH_UP_POS;
               end else begin
                  if (!st.leaving_neutral && item.clutch_position <= CLUTCH_DN_POS) begin
                     res.clutch_set_valid = 1'b1;
                     res.clutch_set_value = CLUTCH_DN_POS;
                  end
                  res.throttle_blip = BLIP_ON;
                  res.buzzer_beep   = 1'b1;
               end
               dur  = tfield(timing.start_times, 3);
               load = 1'b1;
            end
            DN_STEP_PUSH: begin
               if (!n) begin
                  res.throttle_blip = BLIP_OFF;
               end
               res.lever_action = LEVER_PUSH_DOWN;
               dur  = n ? tfield(timing.neutral_times_a, 3) : tfield(timing.down_times, 0);
               load = 1'b1;
            end
            DN_STEP_REBOUND: begin
               res.lever_action = LEVER_REBOUND;
               dur  = n ? tfield(ntb, 0) : tfield(timing.down_times, 1);
               load = 1'b1;
            end
            DN_STEP_BRAKE: begin
               res.clutch_free  = (item.clutch_position <= CLUTCH_REL_POS);
               res.lever_action = LEVER_BRAKE;
               dur  = n ? tfield(ntb, 1) : tfield(timing.down_times, 2);
               load = 1'b1;
            end
            default: ;
         endcase
         if (load) begin
            cnt          = {1'b0, dur} + COUNT_ONE;
            st.next_step = st.next_step + 4'd1;
         end
      end

      res.shift_busy = st.shifting_up || st.shifting_down;
      res.step_now   = st.next_step;
   end

   assign state_nxt = st;
   assign count_nxt = cnt;
   assign result    = res;

endmodule

// File: hw/rtl/timed_gearshift_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_gearshift_sequencer
// Runs timed up/down gear shift sequences from tick, command and gear-report
// requests; one response with actuator actions per request.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  operation, gear_value, clutch_position
//   rsp      out        rsp_valid/rsp_stall  clutch, ignition, blip, beep, lever, ...
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One request per cycle while the response is not stalled; each request goes
// through the input register, then step logic into the response register.
// Sequencer state updates as each request moves into the response register.
// Synchronous reset clears state and timing registers; csr_ready is always high.
// A stalled response holds the request stage; req_stall follows from it.
// ----------------------------------------------------------------------------
module timed_gearshift_sequencer import gss_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_operation,
   input  logic [2:0]                req_gear_value,
   input  logic [6:0]                req_clutch_position,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_clutch_set_valid,
   output logic [6:0]                rsp_clutch_set_value,
   output logic                      rsp_clutch_free,
   output logic [1:0]                rsp_ignition_cut,
   output logic [1:0]                rsp_throttle_blip,
   output logic                      rsp_buzzer_beep,
   output logic [2:0]                rsp_lever_action,
   output logic [1:0]                rsp_limiter_request,
   output logic                      rsp_shift_busy,
   output logic [3:0]                rsp_step_now,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]               csr_wdata
);

   timing_regs_type    timing;
   logic               in_valid_ff, in_valid_in;
   req_item_type       in_item_ff, in_item_in;
   seq_state_type      state_ff, state_in, state_calc;
   logic [TIME_BITS:0] count_ff, count_in, count_calc;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff, out_item_in, result_calc;
   logic               advance;
   logic               req_take;

   gss_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   gss_step_logic #(.TIME_BITS(TIME_BITS)) u_step (
      .item      (in_item_ff),
      .state_cur (state_ff),
      .count_cur (count_ff),
      .timing    (timing),
      .state_nxt (state_calc),
      .count_nxt (count_calc),
      .result    (result_calc)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      in_item_in   = req_take ? {req_operation, req_gear_value, req_clutch_position}
                              : in_item_ff;
      state_in     = advance ? state_calc : state_ff;
      count_in     = advance ? count_calc : count_ff;
      out_valid_in = advance || (out_valid_ff && rsp_stall);
      out_item_in  = advance ? result_calc : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_clutch_set_valid = out_item_ff.clutch_set_valid;
   assign rsp_clutch_set_value = out_item_ff.clutch_set_value;
   assign rsp_clutch_free      = out_item_ff.clutch_free;
   assign rsp_ignition_cut     = out_item_ff.ignition_cut;
   assign rsp_throttle_blip    = out_item_ff.throttle_blip;
   assign rsp_buzzer_beep      = out_item_ff.buzzer_beep;
   assign rsp_lever_action     = out_item_ff.lever_action;
   assign rsp_limiter_request  = out_item_ff.limiter_request;
   assign rsp_shift_busy       = out_item_ff.shift_busy;
   assign rsp_step_now         = out_item_ff.step_now;

endmodule

// File: hw/rtl/gss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_checker
// Port-level checks on the sequencer response channel, bound to the top level.
// ----------------------------------------------------------------------------
module gss_checker import gss_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_clutch_set_valid,
   input logic [6:0] rsp_clutch_set_value,
   input logic       rsp_clutch_free,
   input logic [1:0] rsp_ignition_cut,
   input logic [1:0] rsp_throttle_blip,
   input logic       rsp_buzzer_beep,
   input logic [2:0] rsp_lever_action,
   input logic [1:0] rsp_limiter_request,
   input logic       rsp_shift_busy,
   input logic [3:0] rsp_step_now
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_step_now)
         && $stable(rsp_lever_action) && $stable(rsp_shift_busy))
      else $error("stalled response changed");

   a_clutch_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_clutch_set_valid
         ? (rsp_clutch_set_value == CLUTCH_UP_POS || rsp_clutch_set_value == CLUTCH_DN_POS)
         : (rsp_clutch_set_value == 7'd0)))
      else $error("bad clutch set value");

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_shift_busy |-> (rsp_step_now == UP_STEP_START
         || rsp_step_now == UP_STEP_END || rsp_step_now == DN_STEP_END))
      else $error("idle sequencer on a mid-sequence step");

   a_limiter_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_limiter_request != LIM_NONE |-> rsp_lever_action == LEVER_NONE
         && !rsp_clutch_set_valid && !rsp_clutch_free && !rsp_buzzer_beep
         && rsp_ignition_cut == CUT_NONE && rsp_throttle_blip == BLIP_NONE)
      else $error("limiter response carries step actions");

endmodule

bind timed_gearshift_sequencer gss_checker u_gss_checker (.*);
